// ----- rtl/core/dif_pkg.sv -----
// dif_pkg: types and constants for the decimal integer formatter.
// No dependencies.
`default_nettype none
package dif_pkg;
    localparam int unsigned NDIG = 20;

    typedef struct packed {
        logic        kind;
        logic [63:0] raw_value;
        logic [1:0]  size_mode;
        logic        left_justify;
        logic        force_plus;
        logic        space_sign;
        logic [6:0]  field_width;
        logic [5:0]  min_digits;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_word;

    typedef logic [NDIG*4-1:0] t_bcd;

    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_64 = 2'd2;
    localparam logic       KIND_SIGNED = 1'b0;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Descriptor of one conversion handed from the digit stage to the emitter.
    typedef struct packed {
        t_bcd       bcd;
        logic [4:0] sig;
        logic [5:0] ndig;
        logic       has_sign;
        logic [7:0] sign_char;
        logic [6:0] pad;
        logic       left;
    } t_job;
endpackage
`default_nettype wire

// ----- rtl/core/dif_b2d.sv -----
// dif_b2d: pipelined binary-to-BCD converter (double dabble, one bit per stage).
// Depends on dif_pkg.
`default_nettype none
module dif_b2d
    import dif_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [VALUE_BITS-1:0] i_mag,
    input  wire t_job           i_job,
    output logic                o_valid,
    output t_job                o_job
);
    logic [VALUE_BITS:0]    r_v;
    logic [VALUE_BITS-1:0]  r_sh [VALUE_BITS+1];
    t_bcd                   r_bcd [VALUE_BITS+1];
    t_job                   r_job [VALUE_BITS+1];

    // stage 0 takes the input; stage s shifts in one more bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[VALUE_BITS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0]  <= i_mag;
            r_bcd[0] <= '0;
            r_job[0] <= i_job;
        end
    end

    for (genvar s = 1; s <= VALUE_BITS; s++) begin : g_st
        t_bcd adj;
        always_comb begin
            for (int d = 0; d < NDIG; d++) begin
                adj[d*4 +: 4] = (r_bcd[s-1][d*4 +: 4] >= 4'd5)
                    ? r_bcd[s-1][d*4 +: 4] + 4'd3 : r_bcd[s-1][d*4 +: 4];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_bcd[s] <= {adj[NDIG*4-2:0], r_sh[s-1][VALUE_BITS-1]};
                r_sh[s]  <= {r_sh[s-1][VALUE_BITS-2:0], 1'b0};
                r_job[s] <= r_job[s-1];
            end
        end
    end

    t_bcd       fb;
    logic [4:0] sig;
    always_comb begin
        fb  = r_bcd[VALUE_BITS];
        sig = '0;
        for (int d = 0; d < NDIG; d++) begin
            if (fb[d*4 +: 4] != 4'd0) sig = 5'(d + 1);
        end
        o_job      = r_job[VALUE_BITS];
        o_job.bcd  = fb;
        o_job.sig  = sig;
        o_job.ndig = (6'(sig) > r_job[VALUE_BITS].ndig) ? 6'(sig) : r_job[VALUE_BITS].ndig;
        o_valid    = r_v[VALUE_BITS];
    end
endmodule
`default_nettype wire

// ----- rtl/core/decimal_integer_formatter_unit.sv -----
// decimal_integer_formatter_unit: printf-style %d / %u text generator.
// Throughput: the digit pipeline takes a word per cycle, but the emitter holds the pipeline
//   while it is still busy with the text of an earlier word.
// Reset: synchronous active-low i_rst_n clears all valid bits and counters.
`default_nettype none
module decimal_integer_formatter_unit
    import dif_pkg::*;
#(
    parameter int VALUE_BITS = 64,
    parameter int MAX_FIELD  = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_word  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_word      o_data
);
    // ---- front stage: width cut, sign, magnitude, lengths ----
    logic [6:0]  bits;
    logic [63:0] mask, v, top, mag;
    logic        neg, has_sign;
    logic [7:0]  sch;
    logic [6:0]  wid, body;
    t_job        fj;
    logic        en;

    always_comb begin
        unique case (i_data.size_mode)
            SIZE_16: bits = 7'd16;
            SIZE_64: bits = 7'd64;
            default: bits = 7'd32;
        endcase
        if (bits > 7'(VALUE_BITS)) bits = 7'(VALUE_BITS);
        mask = (bits == 7'd64) ? '1 : ((64'd1 << bits) - 64'd1);
        v    = i_data.raw_value & mask;
        top  = 64'd1 << (bits - 7'd1);
        neg  = (i_data.kind == KIND_SIGNED) && ((v & top) != 0);
        mag  = neg ? (((~v) + 64'd1) & mask) : v;
        if (neg && mag == 64'd0) mag = top;
        has_sign = 1'b0;
        sch      = CH_SPACE;
        if (i_data.kind == KIND_SIGNED) begin
            if (neg) begin
                has_sign = 1'b1; sch = CH_MINUS;
            end else if (i_data.force_plus) begin
                has_sign = 1'b1; sch = CH_PLUS;
            end else if (i_data.space_sign) begin
                has_sign = 1'b1; sch = CH_SPACE;
            end
        end
        wid = (i_data.field_width > 7'(MAX_FIELD)) ? 7'(MAX_FIELD) : i_data.field_width;
        fj           = '0;
        fj.ndig      = i_data.min_digits;
        fj.has_sign  = has_sign;
        fj.sign_char = sch;
        fj.left      = i_data.left_justify;
        // pad computed after digit count; store width here temporarily
        fj.pad       = wid;
    end

    // ---- digit pipeline ----
    logic b_valid;
    t_job b_job;
    dif_b2d #(.VALUE_BITS(VALUE_BITS)) u_b2d (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(i_valid),
        .i_mag  (mag[VALUE_BITS-1:0]),
        .i_job  (fj),
        .o_valid(b_valid),
        .o_job  (b_job)
    );

    // ---- pad stage: register descriptor, then emitter ----
    logic r_pv;
    t_job r_pj;
    t_job pj;
    always_comb begin
        pj     = b_job;
        body   = 7'(b_job.ndig) + 7'(b_job.has_sign);
        pj.pad = (b_job.pad > body) ? b_job.pad - body : 7'd0;
    end

    // emitter state
    logic       r_busy;
    t_job       r_j;
    logic [1:0] r_ph;       // 0 lead pad, 1 sign, 2 digits, 3 trail pad
    logic [6:0] r_cnt;
    logic       r_ov;
    t_out_word  r_od;
    logic       take_p;
    logic       out_free;

    assign out_free = !r_ov || i_ready;
    assign take_p   = r_pv && !r_busy;
    assign en       = !r_pv || take_p;
    assign o_ready  = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= b_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) r_pj <= pj;
    end

    // next-character logic
    logic       emit;
    logic [7:0] ch;
    logic       fin;
    logic [1:0] n_ph;
    logic [6:0] n_cnt;
    logic [4:0] di;
    always_comb begin
        emit  = 1'b0;
        ch    = CH_SPACE;
        n_ph  = r_ph;
        n_cnt = r_cnt;
        di    = r_cnt[4:0] - 5'd1;
        unique case (r_ph)
            2'd0: begin
                if (r_j.left || r_cnt == 7'd0) begin
                    n_ph = 2'd1;
                end else begin
                    emit = 1'b1; n_cnt = r_cnt - 7'd1;
                end
            end
            2'd1: begin
                n_ph  = 2'd2;
                n_cnt = 7'(r_j.ndig);
                if (r_j.has_sign) begin
                    emit = 1'b1; ch = r_j.sign_char;
                end
            end
            2'd2: begin
                if (r_cnt == 7'd0) begin
                    n_ph = 2'd3; n_cnt = r_j.pad;
                end else begin
                    emit  = 1'b1;
                    ch    = (r_cnt <= 7'(r_j.sig)) ? CH_ZERO + 8'(r_j.bcd[di*4 +: 4]) : CH_ZERO;
                    n_cnt = r_cnt - 7'd1;
                end
            end
            default: begin
                if (r_j.left && r_cnt != 7'd0) begin
                    emit = 1'b1; n_cnt = r_cnt - 7'd1;
                end
            end
        endcase
    end

    // true when nothing follows the current character
    always_comb begin
        unique case (r_ph)
            2'd0:       fin = (n_cnt == 7'd0) && !r_j.has_sign && r_j.ndig == 6'd0;
            2'd1, 2'd2: fin = (n_cnt == 7'd0) && (!r_j.left || r_j.pad == 7'd0);
            default:    fin = !(r_j.left && n_cnt != 7'd0);
        endcase
    end

    logic done_now;
    logic load;
    assign done_now = (r_ph == 2'd3) && !(r_j.left && r_cnt != 7'd0);
    // a new character goes to the output register
    assign load     = r_busy && out_free && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
            r_ph   <= 2'd0;
            r_cnt  <= '0;
        end else begin
            if (load) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (take_p) begin
                r_busy <= 1'b1;
                r_j    <= r_pj;
                r_ph   <= 2'd0;
                r_cnt  <= r_pj.pad;
            end else if (r_busy && (out_free || !emit)) begin
                if (done_now) begin
                    r_busy <= 1'b0;
                end else begin
                    r_ph  <= n_ph;
                    r_cnt <= n_cnt;
                    if (emit) begin
                        r_od <= '{out_char: ch, last_char: fin};
                        if (fin) r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;
endmodule
`default_nettype wire

// ----- rtl/core/dif_checker.sv -----
// dif_checker: port-level assertions for decimal_integer_formatter_unit.
// Depends on dif_pkg; bound to the top level below.
`default_nettype none
module dif_checker
    import dif_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_valid,
    input wire logic      i_ready,
    input wire t_out_word o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("out word dropped");
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.out_char == CH_SPACE || o_data.out_char == CH_MINUS ||
                     o_data.out_char == CH_PLUS ||
                     (o_data.out_char >= CH_ZERO && o_data.out_char <= CH_ZERO + 8'd9)))
        else $error("bad char");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule
bind decimal_integer_formatter_unit dif_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data));
`default_nettype wire
